[rtl/stuffed_frame_encoder_crc16_core_assert.svh]
// assertion macros for the stuffed frame encoder
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef STUFFED_FRAME_ENCODER_CRC16_CORE_ASSERT_SVH
`define STUFFED_FRAME_ENCODER_CRC16_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stuffed frame encoder assertion failed");
`define SFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stuffed frame encoder assertion failed");
`else
`define SFE_ASSERT_NOW(lbl, ante, cons)
`define SFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/sfe_pkg.sv]
// types, register map and crc function for the stuffed frame encoder
// no dependencies
`default_nettype none

package sfe_pkg;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_HEADER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TRAILER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MASK    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POLY    = 3'd4;

    localparam logic [7:0]  HEADER_RST  = 8'hAA;
    localparam logic [7:0]  TRAILER_RST = 8'h55;
    localparam logic [7:0]  ESCAPE_RST  = 8'h7D;
    localparam logic [7:0]  MASK_RST    = 8'h20;
    localparam logic [15:0] POLY_RST    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] trailer_byte;
        logic [7:0] escape_byte;
        logic [7:0] stuff_mask;
    } t_stuff_cfg;

    // one classified payload byte, as queued between front and back
    typedef struct packed {
        logic        hdr;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic [15:0] crc;
    } t_job;

    typedef enum logic [2:0] {
        PH_START,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_TRAILER
    } t_phase;

    // msb-first crc over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/sfe_front.sv]
// front part: accepts payload beats, runs the crc and frame flag, builds jobs
// depends on sfe_pkg
`default_nettype none

module sfe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire sfe_pkg::t_in_beat i_in_beat,
    input  wire logic [15:0]     i_crc_poly,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output sfe_pkg::t_job        o_job
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_in_frame;
    logic        n_in_frame;
    logic [15:0] w_crc_upd;
    logic        w_take;

    assign o_in_ready = !i_q_full;
    assign w_take     = i_in_valid && !i_q_full;
    assign o_push     = w_take;
    assign w_crc_upd  = sfe_pkg::crc16_byte(r_crc, i_in_beat.data_byte, i_crc_poly);

    always_comb begin
        o_job.hdr        = !r_in_frame;
        o_job.data_byte  = i_in_beat.data_byte;
        o_job.final_byte = i_in_beat.final_byte;
        o_job.crc        = w_crc_upd;
    end

    always_comb begin
        n_crc      = r_crc;
        n_in_frame = r_in_frame;
        if (w_take) begin
            if (i_in_beat.final_byte) begin
                n_crc      = sfe_pkg::CRC_INIT;
                n_in_frame = 1'b0;
            end else begin
                n_crc      = w_crc_upd;
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= sfe_pkg::CRC_INIT;
            r_in_frame <= 1'b0;
        end else begin
            r_crc      <= n_crc;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

`default_nettype wire

[rtl/sfe_queue.sv]
// job queue between front and back
// depends on sfe_pkg
`default_nettype none

module sfe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfe_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_valid,
    output sfe_pkg::t_job      o_job,
    output logic               o_full
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sfe_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/sfe_back.sv]
// back part: walks each job through an optional header and stuffed data, then crc and trailer after a final byte
// depends on sfe_pkg
`default_nettype none

module sfe_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire sfe_pkg::t_job       i_job,
    input  wire sfe_pkg::t_stuff_cfg i_cfg,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sfe_pkg::t_out_beat       o_out_beat
);

    sfe_pkg::t_phase    r_phase;
    sfe_pkg::t_phase    n_phase;
    sfe_pkg::t_phase    w_phase;
    logic               r_esc;
    logic               n_esc;
    logic               r_out_valid;
    sfe_pkg::t_out_beat r_out_beat;
    sfe_pkg::t_out_beat w_beat;
    logic [7:0]         w_cur;
    logic               w_special;
    logic               w_adv;
    logic               w_last;

    assign w_adv   = i_job_valid && (!r_out_valid || i_out_ready);
    assign w_phase = (r_phase == sfe_pkg::PH_START && !i_job.hdr) ? sfe_pkg::PH_DATA : r_phase;

    always_comb begin
        case (w_phase)
            sfe_pkg::PH_CRC_HI: w_cur = i_job.crc[15:8];
            sfe_pkg::PH_CRC_LO: w_cur = i_job.crc[7:0];
            default:            w_cur = i_job.data_byte;
        endcase
    end

    assign w_special = (w_cur == i_cfg.header_byte) || (w_cur == i_cfg.trailer_byte)
                    || (w_cur == i_cfg.escape_byte);

    // outputs
    always_comb begin
        w_beat.out_byte     = w_cur;
        w_beat.end_of_frame = 1'b0;
        w_last              = 1'b0;
        case (w_phase)
            sfe_pkg::PH_START: begin
                w_beat.out_byte = i_cfg.header_byte;
            end
            sfe_pkg::PH_DATA, sfe_pkg::PH_CRC_HI, sfe_pkg::PH_CRC_LO: begin
                if (w_special && !r_esc) begin
                    w_beat.out_byte = i_cfg.escape_byte;
                end else begin
                    w_beat.out_byte = r_esc ? (w_cur ^ i_cfg.stuff_mask) : w_cur;
                    w_last = (w_phase == sfe_pkg::PH_DATA) && !i_job.final_byte;
                end
            end
            sfe_pkg::PH_TRAILER: begin
                w_beat.out_byte     = i_cfg.trailer_byte;
                w_beat.end_of_frame = 1'b1;
                w_last              = 1'b1;
            end
            default: begin
                w_beat.out_byte = w_cur;
            end
        endcase
    end

    assign o_pop = w_adv && w_last;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        if (w_adv) begin
            case (w_phase)
                sfe_pkg::PH_START: begin
                    n_phase = sfe_pkg::PH_DATA;
                end
                sfe_pkg::PH_DATA, sfe_pkg::PH_CRC_HI, sfe_pkg::PH_CRC_LO: begin
                    if (w_special && !r_esc) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc = 1'b0;
                        case (w_phase)
                            sfe_pkg::PH_DATA:   n_phase = i_job.final_byte ? sfe_pkg::PH_CRC_HI
                                                                           : sfe_pkg::PH_START;
                            sfe_pkg::PH_CRC_HI: n_phase = sfe_pkg::PH_CRC_LO;
                            default:            n_phase = sfe_pkg::PH_TRAILER;
                        endcase
                    end
                end
                sfe_pkg::PH_TRAILER: begin
                    n_phase = sfe_pkg::PH_START;
                end
                default: begin
                    n_phase = sfe_pkg::PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfe_pkg::PH_START;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_beat <= w_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

[rtl/stuffed_frame_encoder_crc16_core.sv]
// top level of the stuffed frame encoder: register port, front, queue, back
// depends on sfe_pkg, sfe_front, sfe_queue, sfe_back and the assertion header
//
//   channel | direction | handshake                   | beat
//   in      | sink      | i_in_valid / o_in_ready     | data_byte, final_byte
//   out     | source    | o_out_valid / i_out_ready   | out_byte, end_of_frame
//   cfg     | apb slave | psel, penable, pwrite       | paddr, pwdata, prdata
//
// one output byte per cycle while a job is queued and i_out_ready allows; an item takes the back sequencer steps
// (header, data or escape pair, two crc bytes each possibly escaped, trailer)
// crc of a byte is done in the accept cycle; the job then passes the queue and the back output register
// the front takes one beat per cycle while the job queue has room
// synchronous active-low reset clears crc, frame flag, queue and sequencer and reloads the config registers
`default_nettype none
`include "stuffed_frame_encoder_crc16_core_assert.svh"

module stuffed_frame_encoder_crc16_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire sfe_pkg::t_in_beat               i_in_beat,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output sfe_pkg::t_out_beat                   o_out_beat,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfe_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    sfe_pkg::t_stuff_cfg r_cfg;
    logic [15:0]         r_crc_poly;
    logic [sfe_pkg::REG_IDX_W-1:0] w_idx;
    logic                w_wr;
    logic                w_push;
    logic                w_pop;
    logic                w_q_full;
    logic                w_job_valid;
    sfe_pkg::t_job       w_job_in;
    sfe_pkg::t_job       w_job_out;

    assign pready = 1'b1;
    assign w_idx  = paddr[sfe_pkg::PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte  <= sfe_pkg::HEADER_RST;
            r_cfg.trailer_byte <= sfe_pkg::TRAILER_RST;
            r_cfg.escape_byte  <= sfe_pkg::ESCAPE_RST;
            r_cfg.stuff_mask   <= sfe_pkg::MASK_RST;
            r_crc_poly         <= sfe_pkg::POLY_RST;
        end else if (w_wr) begin
            case (w_idx)
                sfe_pkg::REG_HEADER:  r_cfg.header_byte  <= pwdata[7:0];
                sfe_pkg::REG_TRAILER: r_cfg.trailer_byte <= pwdata[7:0];
                sfe_pkg::REG_ESCAPE:  r_cfg.escape_byte  <= pwdata[7:0];
                sfe_pkg::REG_MASK:    r_cfg.stuff_mask   <= pwdata[7:0];
                sfe_pkg::REG_POLY:    r_crc_poly         <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            sfe_pkg::REG_HEADER:  prdata = {24'd0, r_cfg.header_byte};
            sfe_pkg::REG_TRAILER: prdata = {24'd0, r_cfg.trailer_byte};
            sfe_pkg::REG_ESCAPE:  prdata = {24'd0, r_cfg.escape_byte};
            sfe_pkg::REG_MASK:    prdata = {24'd0, r_cfg.stuff_mask};
            sfe_pkg::REG_POLY:    prdata = {16'd0, r_crc_poly};
            default:              prdata = 32'd0;
        endcase
    end

    sfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_crc_poly (r_crc_poly),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    sfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job_out),
        .o_full  (w_q_full)
    );

    sfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .i_cfg       (r_cfg),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // end of frame only ever carries the trailer byte
    `SFE_ASSERT_NOW(a_eof_is_trailer, o_out_valid && o_out_beat.end_of_frame, o_out_beat.out_byte == r_cfg.trailer_byte)
    // a frame is never shorter than header, data and crc, so no two trailers in a row
    `SFE_ASSERT_NEXT(a_no_double_eof, o_out_valid && i_out_ready && o_out_beat.end_of_frame, !(o_out_valid && o_out_beat.end_of_frame))
    // input only stalls when work is queued
    `SFE_ASSERT_NOW(a_stall_has_work, !o_in_ready, w_job_valid)

endmodule

`default_nettype wire
